>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge, next-cycle form.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/core/c8ie_pkg.sv
// Shared constants, codes, types and helpers for the CHIP-8 executor.
// No dependencies.
package c8ie_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int MEM_BYTES     = 4096;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int STK_CW     = $clog2(STACK_DEPTH + 1);
    localparam int WRAP_STEPS = 17 - MEM_AW;

    localparam logic [11:0] PROGRAM_START_RESET = 12'd512;
    localparam logic [3:0]  VF_IDX = 4'hF;

    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    // opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS   = 4'h0;
    localparam logic [3:0] OPG_JP    = 4'h1;
    localparam logic [3:0] OPG_CALL  = 4'h2;
    localparam logic [3:0] OPG_SE    = 4'h3;
    localparam logic [3:0] OPG_SNE   = 4'h4;
    localparam logic [3:0] OPG_SER   = 4'h5;
    localparam logic [3:0] OPG_LD    = 4'h6;
    localparam logic [3:0] OPG_ADD   = 4'h7;
    localparam logic [3:0] OPG_ALU   = 4'h8;
    localparam logic [3:0] OPG_SNER  = 4'h9;
    localparam logic [3:0] OPG_LDI   = 4'hA;
    localparam logic [3:0] OPG_JPV0  = 4'hB;
    localparam logic [3:0] OPG_RND   = 4'hC;
    localparam logic [3:0] OPG_DRAW  = 4'hD;
    localparam logic [3:0] OPG_KEY   = 4'hE;
    localparam logic [3:0] OPG_MISC  = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // 8XYn sub-operations
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // EXKK and FXKK sub-codes
    localparam logic [7:0] KK_SKP    = 8'h9E;
    localparam logic [7:0] KK_SKNP   = 8'hA1;
    localparam logic [7:0] KK_GET_DT = 8'h07;
    localparam logic [7:0] KK_SET_DT = 8'h15;
    localparam logic [7:0] KK_SET_ST = 8'h18;
    localparam logic [7:0] KK_ADD_I  = 8'h1E;
    localparam logic [7:0] KK_FONT   = 8'h29;
    localparam logic [7:0] KK_BCD    = 8'h33;
    localparam logic [7:0] KK_STORE  = 8'h55;
    localparam logic [7:0] KK_LOAD   = 8'h65;

    typedef struct packed {
        logic latch;
        logic misc;
        logic issue_x;
        logic issue_y;
        logic alu;
        logic draw_rd;
        logic draw_wr;
        logic draw_end;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_draw;
        logic n_zero;
        logic last_row;
    } sts_t;

    typedef struct packed {
        logic        we;
        logic [11:0] data;
    } cfg_t;

    // address modulo MEM_BYTES by restoring subtraction
    function automatic logic [MEM_AW-1:0] mem_wrap(input logic [15:0] a);
        logic [16:0] t;
        t = {1'b0, a};
        for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
            if (t >= (17'(MEM_BYTES) << k))
            begin
                t = t - (17'(MEM_BYTES) << k);
            end
        end
        return t[MEM_AW-1:0];
    endfunction

endpackage

>>> rtl/core/c8ie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/c8ie_ctrl.sv
// Sequencer for the CHIP-8 executor: steps each item through the datapath.
// Depends on c8ie_pkg.
module c8ie_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    output logic               out_valid,
    input  logic               out_stall,
    input  c8ie_pkg::sts_t     sts,
    output c8ie_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MISC,
        S_RD_X,
        S_RD_Y,
        S_ALU,
        S_DRAW_RD,
        S_DRAW_WR,
        S_DRAW_END,
        S_FIN
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.latch    = accept;
        cmd.misc     = (state_reg == S_MISC);
        cmd.issue_x  = (state_reg == S_RD_X);
        cmd.issue_y  = (state_reg == S_RD_Y);
        cmd.alu      = (state_reg == S_ALU);
        cmd.draw_rd  = (state_reg == S_DRAW_RD);
        cmd.draw_wr  = (state_reg == S_DRAW_WR);
        cmd.draw_end = (state_reg == S_DRAW_END);
        cmd.finish   = (state_reg == S_FIN) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may replace one taken at this edge
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (c8ie_pkg::action_t'(action) == c8ie_pkg::ACT_EXEC)
                                     ? S_RD_X : S_MISC;
                    end
                end
                S_MISC:     state_reg <= S_FIN;
                S_RD_X:     state_reg <= S_RD_Y;
                S_RD_Y:     state_reg <= S_ALU;
                S_ALU:
                begin
                    if (!sts.is_draw)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= sts.n_zero ? S_DRAW_END : S_DRAW_RD;
                    end
                end
                S_DRAW_RD:  state_reg <= S_DRAW_WR;
                S_DRAW_WR:  state_reg <= sts.last_row ? S_DRAW_END : S_DRAW_RD;
                S_DRAW_END: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/c8ie_datapath.sv
// Datapath of the CHIP-8 executor: registers, memories, ALU, sprite engine.
// Depends on c8ie_pkg and c8ie_ram.
module c8ie_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8ie_pkg::cmd_t       cmd,
    output c8ie_pkg::sts_t       sts,
    input  c8ie_pkg::cfg_t       cfg,
    output logic [11:0]          program_start,
    input  logic [1:0]           action,
    input  logic [15:0]          opcode,
    input  logic [7:0]           random_value,
    input  logic [11:0]          address,
    input  logic [7:0]           write_data,
    input  logic [4:0]           display_row,
    output logic [11:0]          pc,
    output logic [15:0]          index_value,
    output logic [7:0]           flag_value,
    output logic [1:0]           status,
    output logic                 display_changed,
    output logic                 sound_active,
    output logic [63:0]          row_pixels
);

    localparam int MAW = c8ie_pkg::MEM_AW;
    localparam int SAW = c8ie_pkg::STK_AW;
    localparam int SCW = c8ie_pkg::STK_CW;

    // latched item
    c8ie_pkg::action_t act_reg;
    logic [15:0]       op_reg;
    logic [7:0]        rnd_reg;
    logic [11:0]       waddr_reg;
    logic [7:0]        wdat_reg;
    logic [4:0]        row_sel_reg;

    // architectural state
    logic [11:0]       start_reg;
    logic [11:0]       pc_reg;
    logic [15:0]       i_reg;
    logic [7:0]        vf_reg;
    logic [15:0]       vvalid_reg;
    logic [SCW-1:0]    sc_reg;
    logic [7:0]        dly_reg;
    logic [7:0]        snd_reg;
    logic [31:0]       fvalid_reg;

    // working registers
    logic [7:0]        va_reg;
    logic [5:0]        x0_reg;
    logic [4:0]        row_reg;
    logic [MAW-1:0]    ptr_reg;
    logic [3:0]        cnt_reg;
    logic              hit_reg;
    logic              chg_reg;
    c8ie_pkg::status_t st_reg;

    // result register
    logic [11:0]       pc_o_reg;
    logic [15:0]       i_o_reg;
    logic [7:0]        vf_o_reg;
    logic [1:0]        st_o_reg;
    logic              chg_o_reg;
    logic              snd_o_reg;
    logic [63:0]       row_o_reg;

    logic [3:0]        x, y, n, hi, ax;
    logic [7:0]        kk;
    logic [11:0]       nnn;

    logic [7:0]        v_rdata;
    logic [3:0]        v_raddr;
    logic [11:0]       stk_rdata;
    logic [SAW-1:0]    stk_raddr;
    logic [7:0]        mem_rdata;
    logic [63:0]       f_rdata;

    logic [7:0]        va_live, vb_live;

    // ALU outputs
    logic [11:0]       pc_n;
    logic [15:0]       i_n;
    logic              v_we;
    logic [7:0]        v_wd;
    logic              flag_we;
    logic [7:0]        flag_wd;
    logic              push, pop, cls, dly_we, snd_we;
    c8ie_pkg::status_t st_n;
    logic [8:0]        sum9;

    // sprite row
    logic [63:0]       sprite64;
    logic [127:0]      dbl;
    logic [63:0]       mask;
    logic [63:0]       old_row;

    logic              mem_we;
    logic [MAW-1:0]    mem_waddr;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign hi  = op_reg[15:12];
    assign kk  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign ax  = (hi == c8ie_pkg::OPG_JPV0) ? 4'h0 : x;

    assign v_raddr   = cmd.issue_y ? y : ax;
    assign stk_raddr = SAW'(sc_reg - SCW'(1));

    // VF lives in flops; unwritten V registers read as zero
    assign va_live = (ax == c8ie_pkg::VF_IDX) ? vf_reg : (vvalid_reg[ax] ? v_rdata : 8'h00);
    assign vb_live = (y == c8ie_pkg::VF_IDX) ? vf_reg : (vvalid_reg[y] ? v_rdata : 8'h00);

    assign mem_we    = cmd.misc && (act_reg == c8ie_pkg::ACT_WRITE);
    assign mem_waddr = c8ie_pkg::mem_wrap({4'h0, waddr_reg});

    assign sprite64 = {mem_rdata, 56'h0};
    assign dbl      = {sprite64, sprite64} >> x0_reg;
    assign mask     = dbl[63:0];
    assign old_row  = fvalid_reg[row_reg] ? f_rdata : 64'h0;

    assign sts.is_draw  = (hi == c8ie_pkg::OPG_DRAW);
    assign sts.n_zero   = (n == 4'h0);
    assign sts.last_row = ((cnt_reg + 4'd1) == n);

    assign program_start   = start_reg;
    assign pc              = pc_o_reg;
    assign index_value     = i_o_reg;
    assign flag_value      = vf_o_reg;
    assign status          = st_o_reg;
    assign display_changed = chg_o_reg;
    assign sound_active    = snd_o_reg;
    assign row_pixels      = row_o_reg;

    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk   (clk),
        .we    (cmd.alu && v_we && (x != c8ie_pkg::VF_IDX)),
        .waddr (x),
        .wdata (v_wd),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    c8ie_ram #(.WIDTH(12), .DEPTH(c8ie_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (cmd.alu && push),
        .waddr (sc_reg[SAW-1:0]),
        .wdata (pc_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wdat_reg),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    c8ie_ram #(.WIDTH(64), .DEPTH(c8ie_pkg::SCREEN_HEIGHT)) u_frame (
        .clk   (clk),
        .we    (cmd.draw_wr),
        .waddr (row_reg),
        .wdata (old_row ^ mask),
        .raddr (cmd.draw_rd ? row_reg : row_sel_reg),
        .rdata (f_rdata)
    );

    always_comb
    begin
        pc_n    = pc_reg;
        i_n     = i_reg;
        v_we    = 1'b0;
        v_wd    = 8'h00;
        flag_we = 1'b0;
        flag_wd = 8'h00;
        push    = 1'b0;
        pop     = 1'b0;
        cls     = 1'b0;
        dly_we  = 1'b0;
        snd_we  = 1'b0;
        st_n    = c8ie_pkg::ST_OK;
        sum9    = {1'b0, va_reg} + {1'b0, vb_live};
        unique case (hi)
            c8ie_pkg::OPG_SYS:
            begin
                if (op_reg == c8ie_pkg::OP_CLS)
                begin
                    cls  = 1'b1;
                    pc_n = pc_reg + 12'd2;
                end
                else if (op_reg == c8ie_pkg::OP_RET)
                begin
                    if (sc_reg == '0)
                    begin
                        st_n = c8ie_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        pop  = 1'b1;
                        pc_n = stk_rdata + 12'd2;
                    end
                end
                else
                begin
                    pc_n = pc_reg + 12'd2;
                end
            end
            c8ie_pkg::OPG_JP:   pc_n = nnn;
            c8ie_pkg::OPG_CALL:
            begin
                if (sc_reg >= SCW'(c8ie_pkg::STACK_DEPTH))
                begin
                    st_n = c8ie_pkg::ST_OVERFLOW;
                end
                else
                begin
                    push = 1'b1;
                    pc_n = nnn;
                end
            end
            c8ie_pkg::OPG_SE:   pc_n = pc_reg + ((va_reg == kk) ? 12'd4 : 12'd2);
            c8ie_pkg::OPG_SNE:  pc_n = pc_reg + ((va_reg != kk) ? 12'd4 : 12'd2);
            c8ie_pkg::OPG_SER:  pc_n = pc_reg + ((va_reg == vb_live) ? 12'd4 : 12'd2);
            c8ie_pkg::OPG_LD:
            begin
                v_we = 1'b1;
                v_wd = kk;
                pc_n = pc_reg + 12'd2;
            end
            c8ie_pkg::OPG_ADD:
            begin
                v_we = 1'b1;
                v_wd = va_reg + kk;
                pc_n = pc_reg + 12'd2;
            end
            c8ie_pkg::OPG_ALU:
            begin
                v_we    = 1'b1;
                flag_we = 1'b1;
                pc_n    = pc_reg + 12'd2;
                unique case (n)
                    c8ie_pkg::ALU_MOV:
                    begin
                        v_wd    = vb_live;
                        flag_we = 1'b0;
                    end
                    c8ie_pkg::ALU_OR:
                    begin
                        v_wd    = va_reg | vb_live;
                        flag_we = 1'b0;
                    end
                    c8ie_pkg::ALU_AND:
                    begin
                        v_wd    = va_reg & vb_live;
                        flag_we = 1'b0;
                    end
                    c8ie_pkg::ALU_XOR:
                    begin
                        v_wd    = va_reg ^ vb_live;
                        flag_we = 1'b0;
                    end
                    c8ie_pkg::ALU_ADD:
                    begin
                        v_wd    = sum9[7:0];
                        flag_wd = {7'h0, sum9[8]};
                    end
                    c8ie_pkg::ALU_SUB:
                    begin
                        v_wd    = va_reg - vb_live;
                        flag_wd = {7'h0, va_reg > vb_live};
                    end
                    c8ie_pkg::ALU_SHR:
                    begin
                        v_wd    = {1'b0, va_reg[7:1]};
                        flag_wd = {7'h0, va_reg[0]};
                    end
                    c8ie_pkg::ALU_SBN:
                    begin
                        v_wd    = vb_live - va_reg;
                        flag_wd = {7'h0, vb_live > va_reg};
                    end
                    c8ie_pkg::ALU_SHL:
                    begin
                        v_wd    = {va_reg[6:0], 1'b0};
                        flag_wd = {7'h0, va_reg[7]};
                    end
                    default:
                    begin
                        v_we    = 1'b0;
                        flag_we = 1'b0;
                        pc_n    = pc_reg;
                        st_n    = c8ie_pkg::ST_ILLEGAL;
                    end
                endcase
            end
            c8ie_pkg::OPG_SNER:
            begin
                if (n != 4'h0)
                begin
                    st_n = c8ie_pkg::ST_ILLEGAL;
                end
                else
                begin
                    pc_n = pc_reg + ((va_reg != vb_live) ? 12'd4 : 12'd2);
                end
            end
            c8ie_pkg::OPG_LDI:
            begin
                i_n  = {4'h0, nnn};
                pc_n = pc_reg + 12'd2;
            end
            c8ie_pkg::OPG_JPV0: pc_n = nnn + {4'h0, va_reg};
            c8ie_pkg::OPG_RND:
            begin
                v_we = 1'b1;
                v_wd = rnd_reg & kk;
                pc_n = pc_reg + 12'd2;
            end
            c8ie_pkg::OPG_DRAW: pc_n = pc_reg;  // PC moves at the end of the draw
            c8ie_pkg::OPG_KEY:
            begin
                if ((kk == c8ie_pkg::KK_SKP) || (kk == c8ie_pkg::KK_SKNP))
                begin
                    pc_n = pc_reg + 12'd2;
                end
                else
                begin
                    st_n = c8ie_pkg::ST_ILLEGAL;
                end
            end
            c8ie_pkg::OPG_MISC:
            begin
                pc_n = pc_reg + 12'd2;
                unique case (kk)
                    c8ie_pkg::KK_GET_DT:
                    begin
                        v_we = 1'b1;
                        v_wd = dly_reg;
                    end
                    c8ie_pkg::KK_SET_DT: dly_we = 1'b1;
                    c8ie_pkg::KK_SET_ST: snd_we = 1'b1;
                    c8ie_pkg::KK_ADD_I:  i_n = i_reg + {8'h0, va_reg};
                    c8ie_pkg::KK_FONT, c8ie_pkg::KK_BCD,
                    c8ie_pkg::KK_STORE, c8ie_pkg::KK_LOAD: ;
                    default:
                    begin
                        pc_n = pc_reg;
                        st_n = c8ie_pkg::ST_ILLEGAL;
                    end
                endcase
            end
            default: pc_n = pc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= c8ie_pkg::PROGRAM_START_RESET;
            pc_reg     <= c8ie_pkg::PROGRAM_START_RESET;
            i_reg      <= 16'h0;
            vf_reg     <= 8'h0;
            vvalid_reg <= 16'h0;
            sc_reg     <= '0;
            dly_reg    <= 8'h0;
            snd_reg    <= 8'h0;
            fvalid_reg <= 32'h0;
            act_reg    <= c8ie_pkg::ACT_EXEC;
            st_reg     <= c8ie_pkg::ST_OK;
            chg_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            cnt_reg    <= 4'h0;
        end
        else
        begin
            if (cfg.we)
            begin
                start_reg <= cfg.data;
                pc_reg    <= cfg.data;
            end

            if (cmd.latch)
            begin
                act_reg <= c8ie_pkg::action_t'(action);
                st_reg  <= c8ie_pkg::ST_OK;
                chg_reg <= 1'b0;
            end

            if (cmd.misc && (act_reg == c8ie_pkg::ACT_TICK))
            begin
                if (dly_reg != 8'h0)
                begin
                    dly_reg <= dly_reg - 8'd1;
                end
                if (snd_reg != 8'h0)
                begin
                    snd_reg <= snd_reg - 8'd1;
                end
            end

            if (cmd.alu)
            begin
                st_reg <= st_n;
                i_reg  <= i_n;
                if (!sts.is_draw)
                begin
                    pc_reg <= pc_n;
                end
                // the flag wins when VF is also the destination
                if (flag_we)
                begin
                    vf_reg <= flag_wd;
                end
                else if (v_we && (x == c8ie_pkg::VF_IDX))
                begin
                    vf_reg <= v_wd;
                end
                if (v_we && (x != c8ie_pkg::VF_IDX))
                begin
                    vvalid_reg[x] <= 1'b1;
                end
                if (push)
                begin
                    sc_reg <= sc_reg + SCW'(1);
                end
                if (pop)
                begin
                    sc_reg <= sc_reg - SCW'(1);
                end
                if (cls)
                begin
                    fvalid_reg <= 32'h0;
                    chg_reg    <= 1'b1;
                end
                if (dly_we)
                begin
                    dly_reg <= va_reg;
                end
                if (snd_we)
                begin
                    snd_reg <= va_reg;
                end
                cnt_reg <= 4'h0;
                hit_reg <= 1'b0;
            end

            if (cmd.draw_wr)
            begin
                fvalid_reg[row_reg] <= 1'b1;
                cnt_reg             <= cnt_reg + 4'd1;
                if (|(old_row & mask))
                begin
                    hit_reg <= 1'b1;
                end
                if (|mask)
                begin
                    chg_reg <= 1'b1;
                end
            end

            if (cmd.draw_end)
            begin
                vf_reg <= {7'h0, hit_reg};
                pc_reg <= pc_reg + 12'd2;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= opcode;
            rnd_reg     <= random_value;
            waddr_reg   <= address;
            wdat_reg    <= write_data;
            row_sel_reg <= display_row;
        end
        if (cmd.issue_y)
        begin
            va_reg <= va_live;
        end
        if (cmd.alu)
        begin
            x0_reg  <= va_reg[5:0];
            row_reg <= vb_live[4:0];
            ptr_reg <= c8ie_pkg::mem_wrap(i_reg);
        end
        if (cmd.draw_wr)
        begin
            row_reg <= row_reg + 5'd1;
            ptr_reg <= (ptr_reg == MAW'(c8ie_pkg::MEM_BYTES - 1)) ? '0 : ptr_reg + MAW'(1);
        end
        if (cmd.finish)
        begin
            pc_o_reg  <= pc_reg;
            i_o_reg   <= i_reg;
            vf_o_reg  <= vf_reg;
            st_o_reg  <= st_reg;
            chg_o_reg <= chg_reg;
            snd_o_reg <= (snd_reg != 8'h0);
            row_o_reg <= ((act_reg == c8ie_pkg::ACT_READ) && fvalid_reg[row_sel_reg])
                         ? f_rdata : 64'h0;
        end
    end

endmodule

>>> rtl/core/chip8_instruction_executor_top.sv
// Top level of the CHIP-8 executor: APB register decode, sequencer, datapath.
// Depends on c8ie_pkg, c8ie_ctrl, c8ie_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | action opcode random_value address
//           |                        | write_data display_row
//  out      | out_valid / out_stall  | pc index_value flag_value status
//           |                        | display_changed sound_active row_pixels
//  cfg      | APB, pready tied high  | program_start at byte address 0
//
// One item at a time. Write, row read and tick take a misc step; an opcode reads
// X and Y and runs the ALU; DXYN adds a read and a write-back step per sprite
// row, then an end step. The V register file and program memory each give one
// read per cycle, so operands are fetched in turn. Reset clears the display at
// once through per-row valid bits, with no clearing pass. A stalled result holds
// the block in its last step; the next item is taken while a result waits.
module chip8_instruction_executor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] opcode,
    input  logic [7:0]  random_value,
    input  logic [11:0] address,
    input  logic [7:0]  write_data,
    input  logic [4:0]  display_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] pc,
    output logic [15:0] index_value,
    output logic [7:0]  flag_value,
    output logic [1:0]  status,
    output logic        display_changed,
    output logic        sound_active,
    output logic [63:0] row_pixels
);

    c8ie_pkg::cmd_t cmd;
    c8ie_pkg::sts_t sts;
    c8ie_pkg::cfg_t cfg;
    logic [11:0]    start_value;

    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite && !paddr[2];
    assign cfg.data = pwdata[11:0];
    assign prdata   = paddr[2] ? 32'h0 : {20'h0, start_value};

    c8ie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    c8ie_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg),
        .program_start   (start_value),
        .action          (action),
        .opcode          (opcode),
        .random_value    (random_value),
        .address         (address),
        .write_data      (write_data),
        .display_row     (display_row),
        .pc              (pc),
        .index_value     (index_value),
        .flag_value      (flag_value),
        .status          (status),
        .display_changed (display_changed),
        .sound_active    (sound_active),
        .row_pixels      (row_pixels)
    );

endmodule

>>> rtl/core/c8ie_checker.sv
// Port-level checks for the CHIP-8 executor, bound to the top level.
// Depends on assert_macros.svh and c8ie_pkg.
`include "assert_macros.svh"

module c8ie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  action,
    input logic [15:0] opcode,
    input logic [7:0]  random_value,
    input logic [11:0] address,
    input logic [7:0]  write_data,
    input logic [4:0]  display_row,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] pc,
    input logic [15:0] index_value,
    input logic [7:0]  flag_value,
    input logic [1:0]  status,
    input logic        display_changed,
    input logic        sound_active,
    input logic [63:0] row_pixels
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // one item at a time: busy straight after an accept
    `ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second item taken while busy")

    // only a row read returns pixels, and it neither draws nor faults
    `ASSERT_CLK(a_row_only,
        !out_valid || (row_pixels == 64'h0) || (!display_changed && status == c8ie_pkg::ST_OK),
        "row data on a non-read result")

    // faulting opcodes never touch the display
    `ASSERT_CLK(a_fault_clean,
        !out_valid || (status == c8ie_pkg::ST_OK) || !display_changed,
        "display changed by a faulting opcode")

endmodule

bind chip8_instruction_executor_top c8ie_checker u_chk (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for chip8_instruction_executor_top: directed items, then random programs.
// Depends on c8ie_pkg and the RTL under rtl/core.
module tb;
    import c8ie_pkg::*;

    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 220;
    localparam int IDLE_LIMIT  = 4000;
    localparam int N_DIRECTED  = 25;

    typedef struct packed {
        action_t     act;
        logic [15:0] op;
        logic [7:0]  rnd;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [4:0]  row;
    } item_t;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  vf;
        status_t     stat;
        logic        chg;
        logic        snd;
        logic [63:0] pix;
    } cpu_view_t;

    // lit: pc and status of the row are typed in
    typedef struct packed {
        item_t       it;
        logic        lit;
        logic [11:0] lpc;
        status_t     lst;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{'{ACT_READ,  16'h0000, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_OK},
        '{'{ACT_EXEC,  OP_RET,   8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_UNDERFLOW},
        '{'{ACT_EXEC,  16'h8008, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_ILLEGAL},
        '{'{ACT_EXEC,  16'h8ABF, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_ILLEGAL},
        '{'{ACT_EXEC,  16'h9AB1, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_ILLEGAL},
        '{'{ACT_EXEC,  16'hE0FF, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_ILLEGAL},
        '{'{ACT_EXEC,  16'hF0FF, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'd512, ST_ILLEGAL},
        '{'{ACT_WRITE, 16'h0000, 8'h00, 12'h300, 8'hFF, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_WRITE, 16'h0000, 8'h00, 12'h301, 8'h81, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_WRITE, 16'hFFFF, 8'hFF, 12'hFFF, 8'hAA, 5'd31}, 1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'hA300, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'h60FF, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'h611F, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'hD012, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'hD012, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'hD011, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_READ,  16'h0000, 8'h00, 12'h000, 8'h00, 5'd31}, 1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'hC5FF, 8'hA5, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'h8F04, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'h8F0E, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'hF018, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_TICK,  16'h0000, 8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'h2FFE, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'hFFE, ST_OK},
        '{'{ACT_EXEC,  OP_CLS,   8'h00, 12'h000, 8'h00, 5'd0},  1'b0, 12'd0,   ST_OK},
        '{'{ACT_EXEC,  16'h1000, 8'h00, 12'h000, 8'h00, 5'd0},  1'b1, 12'h000, ST_OK}
    };

    localparam logic [7:0] MISC_KK [10] = '{KK_GET_DT, KK_SET_DT, KK_SET_ST, KK_ADD_I,
        KK_FONT, KK_BCD, KK_STORE, KK_LOAD, KK_GET_DT, KK_SET_ST};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic [15:0] opcode = '0;
    logic [7:0]  random_value = '0;
    logic [11:0] address = '0;
    logic [7:0]  write_data = '0;
    logic [4:0]  display_row = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] pc;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic [1:0]  status;
    logic        display_changed, sound_active;
    logic [63:0] row_pixels;

    chip8_instruction_executor_top DUT (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // shadow CPU state
    logic [11:0] start_pc, cpu_pc;
    logic [15:0] cpu_i;
    logic [7:0]  cpu_v [16];
    logic [11:0] cpu_stack [STACK_DEPTH];
    int          cpu_sp;
    logic [7:0]  cpu_dt, cpu_st;
    logic [7:0]  cpu_mem [MEM_BYTES];
    bit          mem_known [MEM_BYTES];
    logic [63:0] cpu_fb [SCREEN_HEIGHT];

    cpu_view_t expected_q [$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;
    int        stall_left = 0;

    // step the shadow CPU by one item and return what the block should report
    function automatic cpu_view_t cpu_step(input item_t it);
        cpu_view_t   r;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, a, b, bits;
        logic [11:0] nnn;
        logic [8:0]  res;
        logic        f, has_f, hit;
        int          col, line;
        x = it.op[11:8];
        y = it.op[7:4];
        n = it.op[3:0];
        kk = it.op[7:0];
        nnn = it.op[11:0];
        r = '0;
        r.stat = ST_OK;
        case (it.act)
            ACT_EXEC:
            begin
                case (it.op[15:12])
                    OPG_SYS:
                    begin
                        if (it.op == OP_CLS)
                        begin
                            foreach (cpu_fb[k]) cpu_fb[k] = '0;
                            r.chg = 1'b1;
                        end
                        else if (it.op == OP_RET)
                        begin
                            if (cpu_sp == 0) r.stat = ST_UNDERFLOW;
                            else
                            begin
                                cpu_sp--;
                                cpu_pc = cpu_stack[cpu_sp];
                            end
                        end
                        if (r.stat == ST_OK) cpu_pc += 12'd2;
                    end
                    OPG_JP: cpu_pc = nnn;
                    OPG_CALL:
                    begin
                        if (cpu_sp >= STACK_DEPTH) r.stat = ST_OVERFLOW;
                        else
                        begin
                            cpu_stack[cpu_sp] = cpu_pc;
                            cpu_sp++;
                            cpu_pc = nnn;
                        end
                    end
                    OPG_SE:  cpu_pc += (cpu_v[x] == kk) ? 12'd4 : 12'd2;
                    OPG_SNE: cpu_pc += (cpu_v[x] != kk) ? 12'd4 : 12'd2;
                    OPG_SER: cpu_pc += (cpu_v[x] == cpu_v[y]) ? 12'd4 : 12'd2;
                    OPG_LD:
                    begin
                        cpu_v[x] = kk;
                        cpu_pc += 12'd2;
                    end
                    OPG_ADD:
                    begin
                        cpu_v[x] = cpu_v[x] + kk;
                        cpu_pc += 12'd2;
                    end
                    OPG_ALU:
                    begin
                        a = cpu_v[x];
                        b = cpu_v[y];
                        has_f = 1'b1;
                        f = 1'b0;
                        res = '0;
                        case (n)
                            ALU_MOV: begin res = {1'b0, b}; has_f = 1'b0; end
                            ALU_OR:  begin res = {1'b0, a | b}; has_f = 1'b0; end
                            ALU_AND: begin res = {1'b0, a & b}; has_f = 1'b0; end
                            ALU_XOR: begin res = {1'b0, a ^ b}; has_f = 1'b0; end
                            ALU_ADD: begin res = a + b; f = res[8]; end
                            ALU_SUB: begin res = a - b; f = a > b; end
                            ALU_SHR: begin res = {1'b0, a >> 1}; f = a[0]; end
                            ALU_SBN: begin res = b - a; f = b > a; end
                            ALU_SHL: begin res = {1'b0, a << 1}; f = a[7]; end
                            default: r.stat = ST_ILLEGAL;
                        endcase
                        if (r.stat == ST_OK)
                        begin
                            cpu_v[x] = res[7:0];
                            if (has_f) cpu_v[VF_IDX] = {7'd0, f};
                            cpu_pc += 12'd2;
                        end
                    end
                    OPG_SNER:
                    begin
                        if (n != 4'h0) r.stat = ST_ILLEGAL;
                        else cpu_pc += (cpu_v[x] != cpu_v[y]) ? 12'd4 : 12'd2;
                    end
                    OPG_LDI:
                    begin
                        cpu_i = {4'h0, nnn};
                        cpu_pc += 12'd2;
                    end
                    OPG_JPV0: cpu_pc = nnn + {4'h0, cpu_v[0]};
                    OPG_RND:
                    begin
                        cpu_v[x] = it.rnd & kk;
                        cpu_pc += 12'd2;
                    end
                    OPG_DRAW:
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < n; i++)
                        begin
                            bits = cpu_mem[(cpu_i + i) % MEM_BYTES];
                            line = (cpu_v[y] % SCREEN_HEIGHT + i) % SCREEN_HEIGHT;
                            for (int j = 0; j < 8; j++)
                            begin
                                if (bits[7-j])
                                begin
                                    col = (cpu_v[x] % SCREEN_WIDTH + j) % SCREEN_WIDTH;
                                    if (cpu_fb[line][63-col]) hit = 1'b1;
                                    cpu_fb[line][63-col] = ~cpu_fb[line][63-col];
                                    r.chg = 1'b1;
                                end
                            end
                        end
                        cpu_v[VF_IDX] = {7'd0, hit};
                        cpu_pc += 12'd2;
                    end
                    OPG_KEY:
                    begin
                        if (kk != KK_SKP && kk != KK_SKNP) r.stat = ST_ILLEGAL;
                        else cpu_pc += 12'd2;
                    end
                    default:
                    begin
                        case (kk)
                            KK_GET_DT: cpu_v[x] = cpu_dt;
                            KK_SET_DT: cpu_dt = cpu_v[x];
                            KK_SET_ST: cpu_st = cpu_v[x];
                            KK_ADD_I:  cpu_i = cpu_i + {8'h00, cpu_v[x]};
                            KK_FONT, KK_BCD, KK_STORE, KK_LOAD: ;
                            default:   r.stat = ST_ILLEGAL;
                        endcase
                        if (r.stat == ST_OK) cpu_pc += 12'd2;
                    end
                endcase
            end
            ACT_WRITE:
            begin
                cpu_mem[it.addr] = it.wdata;
                mem_known[it.addr] = 1'b1;
            end
            ACT_READ: r.pix = cpu_fb[it.row];
            default:
            begin
                if (cpu_dt != 0) cpu_dt--;
                if (cpu_st != 0) cpu_st--;
            end
        endcase
        r.pc = cpu_pc;
        r.idx = cpu_i;
        r.vf = cpu_v[VF_IDX];
        r.snd = cpu_st != 0;
        return r;
    endfunction

    // a sprite may only cover memory that has been written
    function automatic item_t guard_sprite(input item_t it);
        item_t g;
        g = it;
        if (g.act == ACT_EXEC && g.op[15:12] == OPG_DRAW)
            for (int i = 0; i < g.op[3:0]; i++)
                if (!mem_known[(cpu_i + i) % MEM_BYTES]) g.op[3:0] = 4'h0;
        return g;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int          pick;
        logic [3:0]  grp;
        it.rnd = 8'($urandom_range(0, 255));
        it.addr = 12'($urandom_range(0, 4095));
        it.wdata = 8'($urandom_range(0, 255));
        it.row = 5'($urandom_range(0, 31));
        it.op = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 70) it.act = ACT_EXEC;
        else if (pick < 85) it.act = ACT_WRITE;
        else if (pick < 93) it.act = ACT_READ;
        else it.act = ACT_TICK;
        if (it.act == ACT_WRITE && $urandom_range(0, 9) < 7)
            it.addr = 12'(12'h300 + $urandom_range(0, 79));
        grp = it.op[15:12];
        pick = $urandom_range(0, 9);
        case (grp)
            OPG_SYS:  if (pick < 3) it.op = OP_CLS; else if (pick < 8) it.op = OP_RET;
            OPG_ALU:  if (pick < 8) it.op[3:0] = (pick < 7) ? 4'(pick) : ALU_SHL;
            OPG_SNER: if (pick < 8) it.op[3:0] = 4'h0;
            OPG_LDI:  if (pick < 7) it.op[11:0] = 12'(12'h300 + $urandom_range(0, 63));
            OPG_KEY:  if (pick < 7) it.op[7:0] = pick[0] ? KK_SKP : KK_SKNP;
            OPG_MISC: if (pick < 9) it.op[7:0] = MISC_KK[$urandom_range(0, 9)];
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(input item_t raw, input logic lit, input logic [11:0] lpc,
                             input status_t lst);
        item_t     it;
        cpu_view_t e;
        it = guard_sprite(raw);
        e = cpu_step(it);
        if (lit)
        begin
            e.pc = lpc;
            e.stat = lst;
        end
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= it.act;
        opcode <= it.op;
        random_value <= it.rnd;
        address <= it.addr;
        write_data <= it.wdata;
        display_row <= it.row;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        expected_q.push_back(e);
    endtask

    task automatic set_program_start(input logic [11:0] val);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {20'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[11:0] !== val)
        begin
            $error("program_start readback: expected %0h, got %0h", val, prdata[11:0]);
            errors++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        start_pc = val;
        cpu_pc = val;
    endtask

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    // results are taken at the edge after this sample point
    always @(negedge clk)
    begin
        cpu_view_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected, pc %0h", pc);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                check_field("pc", 64'(e.pc), 64'(pc));
                check_field("index_value", 64'(e.idx), 64'(index_value));
                check_field("flag_value", 64'(e.vf), 64'(flag_value));
                check_field("status", 64'(e.stat), 64'(status));
                check_field("display_changed", 64'(e.chg), 64'(display_changed));
                check_field("sound_active", 64'(e.snd), 64'(sound_active));
                check_field("row_pixels", e.pix, row_pixels);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("chip8_instruction_executor_top test failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0) stall_left--;
        else if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
        out_stall <= stall_left > 0;
    end

    initial
    begin
        logic [11:0] phase_start [RAND_PHASES];
        start_pc = PROGRAM_START_RESET;
        cpu_pc = PROGRAM_START_RESET;
        cpu_i = '0;
        cpu_sp = 0;
        cpu_dt = '0;
        cpu_st = '0;
        foreach (cpu_v[k]) cpu_v[k] = '0;
        foreach (cpu_stack[k]) cpu_stack[k] = '0;
        foreach (cpu_mem[k]) cpu_mem[k] = '0;
        foreach (mem_known[k]) mem_known[k] = 1'b0;
        foreach (cpu_fb[k]) cpu_fb[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_item(DIRECTED[k].it, DIRECTED[k].lit, DIRECTED[k].lpc, DIRECTED[k].lst);

        phase_start = '{12'hFFF, 12'h000, 12'h000, 12'h000, PROGRAM_START_RESET};
        phase_start[2] = 12'($urandom_range(0, 4095));
        phase_start[3] = 12'($urandom_range(0, 4095));
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_program_start(phase_start[p]);
            if (p == RAND_PHASES - 1) quiet = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(random_item(), 1'b0, 12'd0, ST_OK);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("chip8_instruction_executor_top test passed");
        else
            $display("chip8_instruction_executor_top test failed");
        $finish;
    end
endmodule
